### hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, constants and pointer helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH   = 16;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_REAR  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_QUERY      = 3'd4
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic read;
    } t_dq_cmd;

    function automatic t_ptr ptr_next(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

    function automatic t_ptr ptr_prev(input t_ptr p);
        t_ptr r;
        if (p == '0) begin
            r = t_ptr'(DEPTH - 1);
        end else begin
            r = p - t_ptr'(1);
        end
        return r;
    endfunction

endpackage

### hdl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]                           o_rd_data_a,
    output logic [WIDTH-1:0]                           o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

### hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Request sequencer: accept, pointer update, entry read, response strobe.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output dq_pkg::t_dq_cmd o_cmd,
    output logic            o_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_valid;
    logic   w_accept;

    // a new request may enter while the previous response is on the ports
    assign busy     = (r_state == S_EXEC) || (r_state == S_READ);
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_valid <= 1'b0;
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_valid <= 1'b0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_valid <= 1'b1;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    r_valid <= 1'b0;
                    r_state <= w_accept ? S_EXEC : S_IDLE;
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd.load = w_accept;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.read = (r_state == S_READ);
    assign o_valid    = r_valid;

endmodule

### hdl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Front and rear pointers, occupancy count, status and the entry store.
// ----------------------------------------------------------------------------
module dq_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dq_pkg::t_dq_cmd                  i_cmd,
    input  logic [dq_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [dq_pkg::WORD_W-1:0] i_item_value,
    output logic signed [dq_pkg::WORD_W-1:0] o_front_value,
    output logic signed [dq_pkg::WORD_W-1:0] o_rear_value,
    output logic                             o_is_empty,
    output logic [dq_pkg::COUNT_W-1:0]       o_entry_count,
    output logic [dq_pkg::STAT_W-1:0]        o_status
);

    logic [dq_pkg::REQ_W-1:0]  r_req;
    logic [dq_pkg::WORD_W-1:0] r_item;

    dq_pkg::t_ptr    r_front, n_front;
    dq_pkg::t_ptr    r_rear,  n_rear;
    dq_pkg::t_cnt    r_count, n_count;
    dq_pkg::t_status r_status, n_status;

    logic                      w_wr_en;
    dq_pkg::t_ptr              w_wr_addr;
    logic                      w_full;
    logic                      w_empty;
    logic [dq_pkg::WORD_W-1:0] w_rd_front;
    logic [dq_pkg::WORD_W-1:0] w_rd_rear;

    assign w_full  = (r_count == dq_pkg::t_cnt'(dq_pkg::DEPTH));
    assign w_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_item <= i_item_value;
        end
    end

    always_comb begin
        n_front   = r_front;
        n_rear    = r_rear;
        n_count   = r_count;
        n_status  = dq_pkg::ST_OK;
        w_wr_en   = 1'b0;
        w_wr_addr = r_rear;
        unique case (r_req)
            dq_pkg::REQ_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = dq_pkg::ST_OVERFLOW;
                end else begin
                    n_front   = dq_pkg::ptr_prev(r_front);
                    w_wr_addr = n_front;
                    w_wr_en   = 1'b1;
                    n_count   = r_count + dq_pkg::t_cnt'(1);
                end
            end
            dq_pkg::REQ_PUSH_REAR: begin
                if (w_full) begin
                    n_status = dq_pkg::ST_OVERFLOW;
                end else begin
                    n_rear  = dq_pkg::ptr_next(r_rear);
                    w_wr_en = 1'b1;
                    n_count = r_count + dq_pkg::t_cnt'(1);
                end
            end
            dq_pkg::REQ_POP_FRONT: begin
                if (w_empty) begin
                    n_status = dq_pkg::ST_UNDERFLOW;
                end else begin
                    n_front = dq_pkg::ptr_next(r_front);
                    n_count = r_count - dq_pkg::t_cnt'(1);
                end
            end
            dq_pkg::REQ_POP_REAR: begin
                if (w_empty) begin
                    n_status = dq_pkg::ST_UNDERFLOW;
                end else begin
                    n_rear  = dq_pkg::ptr_prev(r_rear);
                    n_count = r_count - dq_pkg::t_cnt'(1);
                end
            end
            // query and unused codes leave everything as is
            default: begin
                n_status = dq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_rear   <= '0;
            r_count  <= '0;
            r_status <= dq_pkg::ST_OK;
        end else if (i_cmd.exec) begin
            r_front  <= n_front;
            r_rear   <= n_rear;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    dq_ram #(
        .WIDTH (dq_pkg::WORD_W),
        .DEPTH (dq_pkg::DEPTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en && i_cmd.exec),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (r_item),
        .i_rd_en     (i_cmd.read),
        .i_rd_addr_a (r_front),
        .i_rd_addr_b (dq_pkg::ptr_prev(r_rear)),
        .o_rd_data_a (w_rd_front),
        .o_rd_data_b (w_rd_rear)
    );

    // empty deque reports all ones at both ends
    assign o_front_value = w_empty ? '1 : $signed(w_rd_front);
    assign o_rear_value  = w_empty ? '1 : $signed(w_rd_rear);
    assign o_is_empty    = w_empty;
    assign o_entry_count = dq_pkg::COUNT_W'(r_count);
    assign o_status      = r_status;

endmodule

### hdl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed 32-bit words in a circular buffer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on the o_ ports for exactly one cycle with o_valid high, once the request
// has passed the EXEC and READ states; the receiver cannot hold it off. busy
// is high while the pointers and count update and the entry RAM is read
// through its registered read ports, so a new request is not taken until the
// previous one has been through them, and a new request may be accepted in
// the same cycle in which the previous result is strobed.
module double_ended_queue_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [dq_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [dq_pkg::WORD_W-1:0] i_item_value,
    output logic                             o_valid,
    output logic signed [dq_pkg::WORD_W-1:0] o_front_value,
    output logic signed [dq_pkg::WORD_W-1:0] o_rear_value,
    output logic                             o_is_empty,
    output logic [dq_pkg::COUNT_W-1:0]       o_entry_count,
    output logic [dq_pkg::STAT_W-1:0]        o_status
);

    dq_pkg::t_dq_cmd w_cmd;

    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd),
        .o_valid (o_valid)
    );

    dq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req_type    (i_req_type),
        .i_item_value  (i_item_value),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    // every accepted transaction is followed by its response strobe
    a_resp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("missing response strobe");

    // no strobe without an earlier accepted transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("response strobe without transaction");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_front_value == -1 && o_rear_value == -1))
        else $error("empty deque must report all ones");

    a_overflow_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dq_pkg::ST_OVERFLOW) |-> !o_is_empty)
        else $error("overflow reported on empty deque");

endmodule
